// ===== src/fbrgb_pkg.sv =====
// Shared constants, types and tables for the spectrum bin to RGB pixel block.
// No dependencies; used by fbrgb_loop, fft_bin_to_rgb_pixel_top and fbrgb_checker.
package fbrgb_pkg;

	localparam int SAMPLE_BITS      = 16;
	localparam int ANGLE_ITERATIONS = 16;
	localparam int FRAC_BITS        = 16;
	localparam int LOOP_STAGES      = (ANGLE_ITERATIONS > FRAC_BITS) ? ANGLE_ITERATIONS
	                                                                 : FRAC_BITS;

	localparam int ABS_W   = SAMPLE_BITS + 1;
	localparam int XY_W    = SAMPLE_BITS + 4;
	localparam int Z_W     = 25;
	localparam int HUE_W   = 25;
	localparam int V_W     = 32;
	localparam int S_W     = FRAC_BITS + 1;
	localparam int REM_W   = 22;
	localparam int RECIP_W = 23;
	localparam int CFG_IDX_W = 8;

	localparam logic [HUE_W-1:0] QUARTER_TURN = HUE_W'(90 * 65536);
	localparam logic [HUE_W-1:0] FULL_TURN    = HUE_W'(360 * 65536);
	localparam logic [HUE_W-1:0] SECTOR_SPAN  = HUE_W'(60 * 65536);
	localparam logic [S_W-1:0]   UNIT_Q16     = S_W'(65536);
	// ceil(2^28 / 60): exact floor division by 60 for remainders below 2^22
	localparam logic [RECIP_W-1:0] RECIP_60   = RECIP_W'(4473925);
	localparam int RECIP_SHIFT = 28;
	localparam int CHANNEL_SCALE = 100;
	localparam logic [7:0] CHANNEL_MAX = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_WEIGHT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = CFG_IDX_W'(1);
	localparam logic [15:0] WEIGHT_RESET    = 16'd256;
	localparam logic [15:0] THRESHOLD_RESET = 16'd102;

	// State carried through the angle and division loop
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic [ABS_W-1:0]       rem;
		logic [ABS_W-1:0]       den;
		logic [FRAC_BITS-1:0]   quo;
		logic [V_W-1:0]         v;
		logic                   hit;
		logic                   last;
		logic                   re_zero;
		logic                   mag_zero;
		logic                   re_neg;
		logic                   s_full;
	} loop_t;

	// atan(2^-k) in degrees, Q16, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_q16(input int k);
		logic signed [Z_W-1:0] a;
		case (k)
			0:  a = Z_W'(2949120);
			1:  a = Z_W'(1740967);
			2:  a = Z_W'(919879);
			3:  a = Z_W'(466945);
			4:  a = Z_W'(234379);
			5:  a = Z_W'(117304);
			6:  a = Z_W'(58666);
			7:  a = Z_W'(29335);
			8:  a = Z_W'(14668);
			9:  a = Z_W'(7334);
			10: a = Z_W'(3667);
			11: a = Z_W'(1833);
			12: a = Z_W'(917);
			13: a = Z_W'(458);
			14: a = Z_W'(229);
			15: a = Z_W'(115);
			16: a = Z_W'(57);
			17: a = Z_W'(29);
			18: a = Z_W'(14);
			19: a = Z_W'(7);
			20: a = Z_W'(4);
			21: a = Z_W'(2);
			22: a = Z_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

	// Scale a Q16.16 component by 100, truncate, saturate to a byte
	function automatic logic [7:0] to_channel(input logic [V_W-1:0] comp);
		logic [V_W+6:0] prod;
		logic [V_W-10:0] c;
		prod = (V_W+7)'(comp) * (V_W+7)'(CHANNEL_SCALE);
		c = prod[V_W+6:16];
		return (c > (V_W-9)'(CHANNEL_MAX)) ? CHANNEL_MAX : c[7:0];
	endfunction

endpackage

// ===== src/fbrgb_loop.sv =====
// Pipelined vectoring CORDIC and restoring divider, one step per stage.
// Depends on fbrgb_pkg (loop_t, atan_q16, LOOP_STAGES).
module fbrgb_loop (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  fbrgb_pkg::loop_t     in_item,
	output logic                 out_valid,
	output fbrgb_pkg::loop_t     out_item
);
	import fbrgb_pkg::*;

	loop_t item_s [1:LOOP_STAGES];
	logic  vld_s  [1:LOOP_STAGES];

	for (genvar k = 0; k < LOOP_STAGES; k++) begin : g_stage
		loop_t cur, nxt;
		logic cur_vld;
		logic signed [XY_W-1:0] xs, ys;
		logic [ABS_W-1:0] r2;

		// pick the stage input: loop entry or previous stage
		if (k == 0) begin : g_head
			assign cur     = in_item;
			assign cur_vld = in_valid;
		end else begin : g_body
			assign cur     = item_s[k];
			assign cur_vld = vld_s[k];
		end

		// one rotation step and one quotient bit
		always_comb begin
			nxt = cur;
			xs  = cur.x >>> k;
			ys  = cur.y >>> k;
			r2  = {cur.rem[ABS_W-2:0], 1'b0};
			if (k < ANGLE_ITERATIONS) begin
				if (cur.y > 0) begin
					nxt.x = cur.x + ys;
					nxt.y = cur.y - xs;
					nxt.z = cur.z + atan_q16(k);
				end else begin
					nxt.x = cur.x - ys;
					nxt.y = cur.y + xs;
					nxt.z = cur.z - atan_q16(k);
				end
			end
			if (k < FRAC_BITS) begin
				if (r2 >= cur.den) begin
					nxt.rem = r2 - cur.den;
					nxt.quo = {cur.quo[FRAC_BITS-2:0], 1'b1};
				end else begin
					nxt.rem = r2;
					nxt.quo = {cur.quo[FRAC_BITS-2:0], 1'b0};
				end
			end
		end

		// advance stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[k+1] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[LOOP_STAGES];
	assign out_item  = item_s[LOOP_STAGES];

endmodule

// ===== src/fft_bin_to_rgb_pixel_top.sv =====
// Top level: spectrum bin to RGB pixel, HSV to RGB with CORDIC hue.
// Depends on fbrgb_pkg and fbrgb_loop.

// One pixel per bin, one bin accepted per clock while the output is not
// stalled. An input stage feeds the combined CORDIC/divider loop, one
// iteration per stage, followed by seven stages for hue, sector, fraction,
// products, channel scaling and sector select. When the output item is held
// by the sink, the whole pipeline holds and s_tready drops in the same
// cycle. Configuration writes are always taken (cfg_ready is high) and
// should be made only while no item is in flight.
module fft_bin_to_rgb_pixel_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // real_part[15:0], imag_part, magnitude, level_db
	input  logic        s_tlast,  // last_bin
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // red[7:0], green, blue
	output logic        m_tlast,  // frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [fbrgb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import fbrgb_pkg::*;

	logic [15:0] level_weight_q, level_threshold_q;
	logic en;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_weight_q    <= WEIGHT_RESET;
			level_threshold_q <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEVEL_WEIGHT:    level_weight_q    <= cfg_data;
				REG_LEVEL_THRESHOLD: level_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances when the output slot is free or being taken
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---- stage 1: magnitudes, threshold, value product
	logic signed [ABS_W-1:0] re_ext, im_ext;
	logic [ABS_W-1:0] re_abs, im_abs;
	logic [SAMPLE_BITS-1:0] mag_in;
	logic [15:0] level_in;
	loop_t init_c, item_s1;
	logic vld_s1;

	assign re_ext   = {s_tdata[SAMPLE_BITS-1], s_tdata[SAMPLE_BITS-1:0]};
	assign im_ext   = {s_tdata[16+SAMPLE_BITS-1], s_tdata[16+SAMPLE_BITS-1:16]};
	assign mag_in   = s_tdata[32+SAMPLE_BITS-1:32];
	assign level_in = s_tdata[63:48];
	assign re_abs   = re_ext[ABS_W-1] ? ABS_W'(-re_ext) : ABS_W'(re_ext);
	assign im_abs   = im_ext[ABS_W-1] ? ABS_W'(-im_ext) : ABS_W'(im_ext);

	always_comb begin
		init_c          = '0;
		init_c.x        = XY_W'(signed'({1'b0, re_abs}));
		init_c.y        = XY_W'(signed'({1'b0, mag_in}));
		init_c.rem      = re_abs;
		init_c.den      = im_abs;
		init_c.v        = V_W'(level_in) * V_W'(level_weight_q);
		init_c.hit      = level_in > level_threshold_q;
		init_c.last     = s_tlast;
		init_c.re_zero  = re_abs == '0;
		init_c.mag_zero = mag_in == '0;
		init_c.re_neg   = re_ext[ABS_W-1];
		init_c.s_full   = (im_abs == '0) || (re_abs >= im_abs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= init_c;
		end
	end

	// ---- loop: hue angle and saturation quotient
	loop_t lp;
	logic  lp_valid;

	fbrgb_loop u_loop (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s1),
		.in_item  (item_s1),
		.out_valid(lp_valid),
		.out_item (lp)
	);

	// ---- stage 2: clamp angle, place hue, pick saturation
	logic [HUE_W-1:0] ang_c, hue_c;
	logic [HUE_W-1:0] hue_s2;
	logic [S_W-1:0] s_s2;
	logic [V_W-1:0] v_s2;
	logic hit_s2, last_s2, vld_s2;

	always_comb begin
		if (lp.z < 0) begin
			ang_c = '0;
		end else if (lp.z > signed'({1'b0, QUARTER_TURN})) begin
			ang_c = QUARTER_TURN;
		end else begin
			ang_c = HUE_W'(lp.z);
		end
		if (lp.re_zero) begin
			hue_c = QUARTER_TURN;
		end else if (lp.mag_zero) begin
			hue_c = '0;
		end else if (lp.re_neg && ang_c != '0) begin
			hue_c = FULL_TURN - ang_c;
		end else begin
			hue_c = ang_c;
		end
		if (hue_c >= FULL_TURN) begin
			hue_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= lp_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			hue_s2  <= hue_c;
			s_s2    <= lp.s_full ? UNIT_Q16 : S_W'(lp.quo);
			v_s2    <= lp.v;
			hit_s2  <= lp.hit;
			last_s2 <= lp.last;
		end
	end

	// ---- stage 3: sector and remainder within the sector
	logic [2:0] sector_c, sector_s3;
	logic [HUE_W-1:0] base_c;
	logic [REM_W-1:0] rem_s3;
	logic [S_W-1:0] s_s3;
	logic [V_W-1:0] v_s3;
	logic hit_s3, last_s3, vld_s3;

	always_comb begin
		if (hue_s2 >= HUE_W'(5) * SECTOR_SPAN) begin
			sector_c = 3'd5;
		end else if (hue_s2 >= HUE_W'(4) * SECTOR_SPAN) begin
			sector_c = 3'd4;
		end else if (hue_s2 >= HUE_W'(3) * SECTOR_SPAN) begin
			sector_c = 3'd3;
		end else if (hue_s2 >= HUE_W'(2) * SECTOR_SPAN) begin
			sector_c = 3'd2;
		end else if (hue_s2 >= SECTOR_SPAN) begin
			sector_c = 3'd1;
		end else begin
			sector_c = 3'd0;
		end
		base_c = HUE_W'(sector_c) * SECTOR_SPAN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sector_s3 <= sector_c;
			rem_s3    <= REM_W'(hue_s2 - base_c);
			s_s3      <= s_s2;
			v_s3      <= v_s2;
			hit_s3    <= hit_s2;
			last_s3   <= last_s2;
		end
	end

	// ---- stage 4: fraction = remainder / 60 by reciprocal
	logic [REM_W+RECIP_W-1:0] ff_prod;
	logic [FRAC_BITS-1:0] ff_s4;
	logic [2:0] sector_s4;
	logic [S_W-1:0] s_s4;
	logic [V_W-1:0] v_s4;
	logic hit_s4, last_s4, vld_s4;

	assign ff_prod = (REM_W+RECIP_W)'(rem_s3) * (REM_W+RECIP_W)'(RECIP_60);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ff_s4     <= ff_prod[RECIP_SHIFT+FRAC_BITS-1:RECIP_SHIFT];
			sector_s4 <= sector_s3;
			s_s4      <= s_s3;
			v_s4      <= v_s3;
			hit_s4    <= hit_s3;
			last_s4   <= last_s3;
		end
	end

	// ---- stage 5: s*ff, s*(1-ff) and 1-s
	logic [2*S_W-1:0] sf_prod, st_prod;
	logic [S_W-1:0] sf_s5, st_s5, fp_s5;
	logic [2:0] sector_s5;
	logic [V_W-1:0] v_s5;
	logic hit_s5, last_s5, vld_s5;

	assign sf_prod = (2*S_W)'(s_s4) * (2*S_W)'(ff_s4);
	assign st_prod = (2*S_W)'(s_s4) * (2*S_W)'(UNIT_Q16 - S_W'(ff_s4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sf_s5     <= sf_prod[FRAC_BITS+S_W-1:FRAC_BITS];
			st_s5     <= st_prod[FRAC_BITS+S_W-1:FRAC_BITS];
			fp_s5     <= UNIT_Q16 - s_s4;
			sector_s5 <= sector_s4;
			v_s5      <= v_s4;
			hit_s5    <= hit_s4;
			last_s5   <= last_s4;
		end
	end

	// ---- stage 6: p, q, t components
	logic [V_W+S_W-1:0] p_prod, q_prod, t_prod;
	logic [V_W-1:0] p_s6, q_s6, t_s6, v_s6;
	logic [2:0] sector_s6;
	logic hit_s6, last_s6, vld_s6;

	assign p_prod = (V_W+S_W)'(v_s5) * (V_W+S_W)'(fp_s5);
	assign q_prod = (V_W+S_W)'(v_s5) * (V_W+S_W)'(UNIT_Q16 - sf_s5);
	assign t_prod = (V_W+S_W)'(v_s5) * (V_W+S_W)'(UNIT_Q16 - st_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s6      <= p_prod[FRAC_BITS+V_W-1:FRAC_BITS];
			q_s6      <= q_prod[FRAC_BITS+V_W-1:FRAC_BITS];
			t_s6      <= t_prod[FRAC_BITS+V_W-1:FRAC_BITS];
			v_s6      <= v_s5;
			sector_s6 <= sector_s5;
			hit_s6    <= hit_s5;
			last_s6   <= last_s5;
		end
	end

	// ---- stage 7: scale to bytes
	logic [7:0] vc_s7, pc_s7, qc_s7, tc_s7;
	logic [2:0] sector_s7;
	logic hit_s7, last_s7, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			vc_s7     <= to_channel(v_s6);
			pc_s7     <= to_channel(p_s6);
			qc_s7     <= to_channel(q_s6);
			tc_s7     <= to_channel(t_s6);
			sector_s7 <= sector_s6;
			hit_s7    <= hit_s6;
			last_s7   <= last_s6;
		end
	end

	// ---- stage 8: sector select, black at or below threshold, output item
	logic [7:0] r_c, g_c, b_c;
	logic [23:0] pix_s8;
	logic last_s8, vld_s8;

	always_comb begin
		case (sector_s7)
			3'd0: begin r_c = vc_s7; g_c = tc_s7; b_c = pc_s7; end
			3'd1: begin r_c = qc_s7; g_c = vc_s7; b_c = pc_s7; end
			3'd2: begin r_c = pc_s7; g_c = vc_s7; b_c = tc_s7; end
			3'd3: begin r_c = pc_s7; g_c = qc_s7; b_c = vc_s7; end
			3'd4: begin r_c = tc_s7; g_c = pc_s7; b_c = vc_s7; end
			default: begin r_c = vc_s7; g_c = pc_s7; b_c = qc_s7; end
		endcase
		if (!hit_s7) begin
			r_c = '0;
			g_c = '0;
			b_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s8  <= {b_c, g_c, r_c};
			last_s8 <= last_s7;
		end
	end

	assign m_tvalid = vld_s8;
	assign m_tdata  = pix_s8;
	assign m_tlast  = last_s8;

endmodule

// ===== src/fbrgb_checker.sv =====
// Port-level checks for fft_bin_to_rgb_pixel_top, attached by bind.
// Depends on fbrgb_pkg for the configuration index width.
module fbrgb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [fbrgb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [15:0] cfg_data
);
	// a held output item stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// input ready follows the output slot: high when it is free or being taken
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output slot");

	// a stalled output blocks new items
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
		else $error("item accepted during output stall");

	// configuration writes never wait
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");
endmodule

bind fft_bin_to_rgb_pixel_top fbrgb_checker u_fbrgb_checker (.*);
